>>> rtl/sctg_pkg.sv
// ============================================================================
// sctg_pkg
// Shared types and constants of the serial command sine table generator:
// command characters, command kinds, field limits and the half-sine table.
// ============================================================================
package sctg_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ROM_SIZE        = 32;
    localparam int LIMIT_W         = 14;
    localparam int VALUE_W         = 12;
    localparam int CHAR_W          = 8;
    localparam int SAMPLE_W        = 10;
    localparam int CNT_W           = 3;
    localparam int NUM_W           = 14;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd4095;
    localparam logic [LIMIT_W-1:0] FIELD_MAX   = 14'd4095;

    localparam logic [CHAR_W-1:0] CHAR_SET   = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_ADC   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_START = 8'h73;
    localparam logic [CHAR_W-1:0] CHAR_STOP  = 8'h74;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [CNT_W-1:0] CNT_LAST = 3'd4;

    typedef enum logic [2:0]
    {
        KIND_NONE  = 3'd0,
        KIND_SET   = 3'd1,
        KIND_ADC   = 3'd2,
        KIND_START = 3'd3,
        KIND_STOP  = 3'd4
    } cmd_kind_t;

    localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_SIZE] = '{
        10'd81,  10'd162, 10'd241, 10'd318, 10'd392, 10'd462, 10'd527, 10'd588,
        10'd642, 10'd691, 10'd733, 10'd768, 10'd795, 10'd815, 10'd827, 10'd831,
        10'd827, 10'd815, 10'd795, 10'd768, 10'd733, 10'd691, 10'd642, 10'd588,
        10'd527, 10'd462, 10'd392, 10'd318, 10'd241, 10'd162, 10'd81,  10'd0
    };

endpackage

>>> rtl/sctg_ifs.sv
// ============================================================================
// sctg channel interfaces
// Valid/ready channels for received characters and for result items.
// ============================================================================
interface sctg_char_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] rx_char;

    modport source (output valid, output char_valid, output rx_char, input ready);
    modport sink   (input valid, input char_valid, input rx_char, output ready);
endinterface

interface sctg_result_if;
    logic        valid;
    logic        ready;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic [2:0]  cmd_kind;
    logic [11:0] set_value;
    logic        value_clamped;
    logic        dac_write;
    logic [7:0]  dac_high;
    logic [7:0]  dac_low;
    logic        generating;

    modport source
    (
        output valid, output echo_valid, output echo_char, output cmd_kind,
        output set_value, output value_clamped, output dac_write,
        output dac_high, output dac_low, output generating, input ready
    );
    modport sink
    (
        input valid, input echo_valid, input echo_char, input cmd_kind,
        input set_value, input value_clamped, input dac_write,
        input dac_high, input dac_low, input generating, output ready
    );
endinterface

>>> rtl/serial_cmd_sine_table_generator.sv
// ============================================================================
// serial_cmd_sine_table_generator
// Serial command decoder with a half-sine table generator for a DAC.
//
// char_chan takes one item per tick: an optional received character. Each
// item yields exactly one result item on result_chan: the echo, the decoded
// command kind, the held set value with its clamp flag, and while generating
// the next half-sine table sample as high and low DAC bytes.
// Commands: 'd' plus four decimal characters sets the value (saturated at
// the smaller of value_limit and 4095), 'a' is a no-op request, 's' starts
// and 't' stops generation. Any other first character clears the buffer.
// The result register loads at the edge that accepts the item. Throughput is
// one item per cycle; char_chan.ready stays high while the result register is
// empty or being taken this cycle. When the receiver stalls, the result holds
// and char_chan stalls with it. Reset clears the buffer, the held value, the
// table position and the mode, and sets value_limit to 4095. cfg_we writes
// value_limit; the user must do so while idle; the block does not enforce it.
// ============================================================================
module serial_cmd_sine_table_generator
#(
    parameter int TABLE_DEPTH = sctg_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    sctg_char_if.sink                        char_chan,
    sctg_result_if.source                    result_chan,
    input  logic                             cfg_we,
    input  logic [sctg_pkg::LIMIT_W-1:0]     cfg_wdata
);

    localparam int POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TABLE_DEPTH - 1);

    logic [sctg_pkg::LIMIT_W-1:0]  limit_reg;
    logic                          gen_reg, gen_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [sctg_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sctg_pkg::CHAR_W-1:0]   dig_reg [3];
    logic [sctg_pkg::VALUE_W-1:0]  held_reg, held_next;

    logic                          out_valid_reg;
    logic                          echo_valid_reg;
    logic [sctg_pkg::CHAR_W-1:0]   echo_char_reg;
    sctg_pkg::cmd_kind_t           kind_reg, kind_next;
    logic                          clamp_reg, clamp_next;
    logic                          dac_write_reg;
    logic [sctg_pkg::SAMPLE_W-1:0] sample_reg, sample_next;

    logic                          in_fire;
    logic                          dig_we;
    logic [1:0]                    dig_idx;
    logic [sctg_pkg::CHAR_W-1:0]   parse_chars [4];
    logic [sctg_pkg::NUM_W-1:0]    acc;
    logic                          run;
    logic [sctg_pkg::CHAR_W-1:0]   pc;
    logic [sctg_pkg::VALUE_W-1:0]  lim;
    logic [8:0]                    pos_ext;

    assign in_fire         = char_chan.valid && char_chan.ready;
    assign char_chan.ready = !out_valid_reg || result_chan.ready;

    assign parse_chars[0] = dig_reg[0];
    assign parse_chars[1] = dig_reg[1];
    assign parse_chars[2] = dig_reg[2];
    assign parse_chars[3] = char_chan.rx_char;

    always_comb
    begin
        acc = '0;
        run = 1'b1;
        pc  = '0;
        for (int k = 0; k < 4; k++)
        begin
            pc = parse_chars[k];
            if (run && pc >= sctg_pkg::CHAR_ZERO && pc <= sctg_pkg::CHAR_NINE)
            begin
                acc = sctg_pkg::NUM_W'((acc << 3) + (acc << 1) + {10'b0, pc[3:0]});
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign lim = (limit_reg > sctg_pkg::FIELD_MAX) ? sctg_pkg::FIELD_MAX[11:0]
                                                   : limit_reg[11:0];
    assign dig_idx = 2'(cnt_reg - 3'd1);

    always_comb
    begin
        kind_next  = sctg_pkg::KIND_NONE;
        clamp_next = 1'b0;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        dig_we     = 1'b0;
        if (char_chan.char_valid)
        begin
            if (cnt_reg == '0)
            begin
                unique case (char_chan.rx_char)
                    sctg_pkg::CHAR_SET:   cnt_next  = 3'd1;
                    sctg_pkg::CHAR_ADC:   kind_next = sctg_pkg::KIND_ADC;
                    sctg_pkg::CHAR_START: kind_next = sctg_pkg::KIND_START;
                    sctg_pkg::CHAR_STOP:  kind_next = sctg_pkg::KIND_STOP;
                    default:              kind_next = sctg_pkg::KIND_NONE;
                endcase
            end
            else if (cnt_reg == sctg_pkg::CNT_LAST)
            begin
                kind_next = sctg_pkg::KIND_SET;
                cnt_next  = '0;
                if (acc > {2'b0, lim})
                begin
                    held_next  = lim;
                    clamp_next = 1'b1;
                end
                else
                begin
                    held_next = acc[11:0];
                end
            end
            else
            begin
                dig_we   = 1'b1;
                cnt_next = 3'(cnt_reg + 3'd1);
            end
        end
    end

    assign pos_ext     = 9'(pos_reg);
    assign sample_next = (pos_ext < 9'(sctg_pkg::ROM_SIZE)) ? sctg_pkg::SINE_ROM[pos_ext[4:0]]
                                                             : '0;

    always_comb
    begin
        gen_next = gen_reg;
        pos_next = pos_reg;
        if (!gen_reg)
        begin
            gen_next = (kind_next == sctg_pkg::KIND_START);
        end
        else
        begin
            pos_next = (pos_reg == POS_LAST) ? '0 : POS_W'(pos_reg + 1'b1);
            gen_next = (kind_next != sctg_pkg::KIND_STOP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= sctg_pkg::LIMIT_RESET;
            gen_reg       <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                gen_reg       <= gen_next;
                pos_reg       <= pos_next;
                cnt_reg       <= cnt_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (dig_we)
            begin
                dig_reg[dig_idx] <= char_chan.rx_char;
            end
            echo_valid_reg <= char_chan.char_valid;
            echo_char_reg  <= char_chan.char_valid ? char_chan.rx_char : '0;
            kind_reg       <= kind_next;
            clamp_reg      <= clamp_next;
            dac_write_reg  <= gen_reg;
            sample_reg     <= gen_reg ? sample_next : '0;
        end
    end

    assign result_chan.valid         = out_valid_reg;
    assign result_chan.echo_valid    = echo_valid_reg;
    assign result_chan.echo_char     = echo_char_reg;
    assign result_chan.cmd_kind      = kind_reg;
    assign result_chan.set_value     = held_reg;
    assign result_chan.value_clamped = clamp_reg;
    assign result_chan.dac_write     = dac_write_reg;
    assign result_chan.dac_high      = {6'b0, sample_reg[9:8]};
    assign result_chan.dac_low       = sample_reg[7:0];
    assign result_chan.generating    = gen_reg;

endmodule

>>> rtl/sctg_checker.sv
// ============================================================================
// sctg_checker
// Port-level checks of the serial command sine table generator, bound to
// the top level.
// ============================================================================
module sctg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        echo_valid,
    input logic [7:0]  echo_char,
    input logic [2:0]  cmd_kind,
    input logic        value_clamped,
    input logic        dac_write,
    input logic [7:0]  dac_high,
    input logic [7:0]  dac_low
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cmd_kind) && $stable(dac_low))
        else $error("result item changed while stalled");

    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !echo_valid |-> echo_char == 8'd0)
        else $error("echo character without echo");

    a_clamp_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_clamped |-> cmd_kind == sctg_pkg::KIND_SET)
        else $error("clamp flag outside a set command");

    a_dac_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dac_write |-> dac_high == 8'd0 && dac_low == 8'd0)
        else $error("sample bytes without a DAC write");

endmodule

bind serial_cmd_sine_table_generator sctg_checker u_sctg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_chan.valid),
    .out_ready     (result_chan.ready),
    .echo_valid    (result_chan.echo_valid),
    .echo_char     (result_chan.echo_char),
    .cmd_kind      (result_chan.cmd_kind),
    .value_clamped (result_chan.value_clamped),
    .dac_write     (result_chan.dac_write),
    .dac_high      (result_chan.dac_high),
    .dac_low       (result_chan.dac_low)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Checks the serial command sine table generator. A driver offers received
// characters from a backlog, a monitor predicts each tick's result from its
// own copy of the command buffer, held value, limit and table position, and
// compares every result item field by field. The run covers several value
// limits and idle/stall patterns, plus one long receiver hold-off.
// ============================================================================
module tb;

    localparam int TBL_DEPTH     = sctg_pkg::TABLE_DEPTH_DEF;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 138;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic       char_valid;
        logic [7:0] rx_char;
    } char_item_t;

    typedef struct {
        logic                echo_valid;
        logic [7:0]          echo_char;
        sctg_pkg::cmd_kind_t cmd_kind;
        logic [11:0]         set_value;
        logic                value_clamped;
        logic                dac_write;
        logic [7:0]          dac_high;
        logic [7:0]          dac_low;
        logic                generating;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [sctg_pkg::LIMIT_W-1:0] cfg_wdata;

    sctg_char_if   char_chan();
    sctg_result_if result_chan();

    serial_cmd_sine_table_generator #(.TABLE_DEPTH(TBL_DEPTH)) u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_chan),
        .result_chan(result_chan),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    char_item_t   char_backlog[$];
    tick_result_t results_due[$];

    int unsigned queued_cnt  = 0;
    int unsigned taken_cnt   = 0;
    int unsigned err_cnt     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        char_taken  = 1'b0;
    logic        hold_req    = 1'b0;
    logic        rx_hold     = 1'b0;

    // predictor state
    logic [sctg_pkg::LIMIT_W-1:0] limit_model = sctg_pkg::LIMIT_RESET;
    logic               gen_on      = 1'b0;
    int unsigned        tbl_pos     = 0;
    logic [7:0]         cmd_buf[5]  = '{default: 8'd0};
    int unsigned        buf_fill    = 0;
    logic [11:0]        held_val    = 12'd0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tick_result_t predict_tick(input char_item_t it);
        tick_result_t       r;
        logic [sctg_pkg::LIMIT_W-1:0] lim;
        int unsigned        num;
        int                 k;
        logic               halted;
        logic [sctg_pkg::SAMPLE_W-1:0] smp;
        r.echo_valid    = it.char_valid;
        r.echo_char     = it.char_valid ? it.rx_char : 8'd0;
        r.cmd_kind      = sctg_pkg::KIND_NONE;
        r.value_clamped = 1'b0;
        r.dac_write     = 1'b0;
        r.dac_high      = 8'd0;
        r.dac_low       = 8'd0;
        if (it.char_valid)
        begin
            if (buf_fill < 5)
                cmd_buf[buf_fill] = it.rx_char;
            buf_fill++;
            case (cmd_buf[0])
                sctg_pkg::CHAR_SET:
                    if (buf_fill >= 5)
                    begin
                        lim = (limit_model < sctg_pkg::FIELD_MAX) ? limit_model
                                                                  : sctg_pkg::FIELD_MAX;
                        num = 0;
                        halted = 1'b0;
                        for (k = 1; k < 5; k++)
                        begin
                            if (cmd_buf[k] < sctg_pkg::CHAR_ZERO ||
                                cmd_buf[k] > sctg_pkg::CHAR_NINE)
                                halted = 1'b1;
                            if (!halted)
                                num = num * 10 + (cmd_buf[k] - sctg_pkg::CHAR_ZERO);
                        end
                        if (num > lim)
                        begin
                            num = lim;
                            r.value_clamped = 1'b1;
                        end
                        held_val   = 12'(num);
                        buf_fill   = 0;
                        r.cmd_kind = sctg_pkg::KIND_SET;
                    end
                sctg_pkg::CHAR_ADC:
                begin
                    r.cmd_kind = sctg_pkg::KIND_ADC;
                    buf_fill   = 0;
                end
                sctg_pkg::CHAR_START:
                begin
                    r.cmd_kind = sctg_pkg::KIND_START;
                    buf_fill   = 0;
                end
                sctg_pkg::CHAR_STOP:
                begin
                    r.cmd_kind = sctg_pkg::KIND_STOP;
                    buf_fill   = 0;
                end
                default:
                    buf_fill = 0;
            endcase
        end
        if (!gen_on)
        begin
            if (r.cmd_kind == sctg_pkg::KIND_START)
                gen_on = 1'b1;
        end
        else
        begin
            smp = (tbl_pos < sctg_pkg::ROM_SIZE) ? sctg_pkg::SINE_ROM[tbl_pos] : '0;
            tbl_pos = (tbl_pos + 1 >= TBL_DEPTH) ? 0 : tbl_pos + 1;
            r.dac_write = 1'b1;
            r.dac_high  = 8'(smp >> 8);
            r.dac_low   = smp[7:0];
            if (r.cmd_kind == sctg_pkg::KIND_STOP)
                gen_on = 1'b0;
        end
        r.set_value  = held_val;
        r.generating = gen_on;
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic push_char(input logic cv, input logic [7:0] c);
        char_item_t it;
        it.char_valid = cv;
        it.rx_char    = c;
        char_backlog.push_back(it);
        queued_cnt++;
    endtask

    task automatic push_set(input logic [7:0] c1, input logic [7:0] c2,
                            input logic [7:0] c3, input logic [7:0] c4);
        push_char(1'b1, sctg_pkg::CHAR_SET);
        push_char(1'b1, c1);
        push_char(1'b1, c2);
        push_char(1'b1, c3);
        push_char(1'b1, c4);
    endtask

    task automatic push_random_command();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            push_char(1'b1, sctg_pkg::CHAR_SET);
            for (k = 0; k < 4; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_char(1'b0, 8'($urandom));
                if ($urandom_range(0, 99) < 85)
                    push_char(1'b1, sctg_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                else
                    push_char(1'b1, 8'($urandom));
            end
        end
        else if (pick < 45)
            push_char(1'b1, sctg_pkg::CHAR_ADC);
        else if (pick < 57)
            push_char(1'b1, sctg_pkg::CHAR_START);
        else if (pick < 66)
            push_char(1'b1, sctg_pkg::CHAR_STOP);
        else if (pick < 76)
            push_char(1'b1, 8'($urandom));
        else
            repeat ($urandom_range(1, 6)) push_char(1'b0, 8'($urandom));
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        do
        begin
            @(negedge clk);
            n++;
        end
        while ((taken_cnt != queued_cnt || results_due.size() != 0) && n < DRAIN_LIMIT);
    endtask

    task automatic write_limit(input logic [sctg_pkg::LIMIT_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // driver
    always @(negedge clk)
    begin : drive_chars
        char_item_t nxt;
        if (!rst_n)
            char_chan.valid <= 1'b0;
        else if (!char_chan.valid || char_taken)
        begin
            char_taken = 1'b0;
            if (char_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = char_backlog.pop_front();
                char_chan.valid      <= 1'b1;
                char_chan.char_valid <= nxt.char_valid;
                char_chan.rx_char    <= nxt.rx_char;
            end
            else
                char_chan.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
            result_chan.ready <= 1'b0;
        else
            result_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin : long_stall
        wait (hold_req);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin : observe
        tick_result_t want;
        char_item_t   got_in;
        if (rst_n)
        begin
            if (cfg_we)
                limit_model = cfg_wdata;
            if (result_chan.valid && result_chan.ready)
            begin
                if (results_due.size() == 0)
                    note_error("result item with nothing expected");
                else
                begin
                    want = results_due.pop_front();
                    if (result_chan.echo_valid !== want.echo_valid)
                        note_error($sformatf("echo_valid exp %0h got %0h",
                                             want.echo_valid, result_chan.echo_valid));
                    if (result_chan.echo_char !== want.echo_char)
                        note_error($sformatf("echo_char exp %0h got %0h",
                                             want.echo_char, result_chan.echo_char));
                    if (result_chan.cmd_kind !== want.cmd_kind)
                        note_error($sformatf("cmd_kind exp %0d got %0d",
                                             want.cmd_kind, result_chan.cmd_kind));
                    if (result_chan.set_value !== want.set_value)
                        note_error($sformatf("set_value exp %0d got %0d",
                                             want.set_value, result_chan.set_value));
                    if (result_chan.value_clamped !== want.value_clamped)
                        note_error($sformatf("value_clamped exp %0h got %0h",
                                             want.value_clamped, result_chan.value_clamped));
                    if (result_chan.dac_write !== want.dac_write)
                        note_error($sformatf("dac_write exp %0h got %0h",
                                             want.dac_write, result_chan.dac_write));
                    if (result_chan.dac_high !== want.dac_high)
                        note_error($sformatf("dac_high exp %0h got %0h",
                                             want.dac_high, result_chan.dac_high));
                    if (result_chan.dac_low !== want.dac_low)
                        note_error($sformatf("dac_low exp %0h got %0h",
                                             want.dac_low, result_chan.dac_low));
                    if (result_chan.generating !== want.generating)
                        note_error($sformatf("generating exp %0h got %0h",
                                             want.generating, result_chan.generating));
                end
            end
            if (char_chan.valid && char_chan.ready)
            begin
                got_in.char_valid = char_chan.char_valid;
                got_in.rx_char    = char_chan.rx_char;
                results_due.push_back(predict_tick(got_in));
                taken_cnt++;
                char_taken = 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : run_test
        int unsigned lim_set[PHASES];
        int unsigned idle_set[PHASES];
        int unsigned stall_set[PHASES];
        int          p;
        int unsigned goal;
        lim_set   = '{0, 9999, 8191, 4094, 4096, 0};
        idle_set  = '{0, 54, 0, 22, 54, 0};
        stall_set = '{0, 0, 54, 22, 0, 54};
        lim_set[PHASES-1] = $urandom_range(0, 9999);

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        char_chan.valid      = 1'b0;
        char_chan.char_valid = 1'b0;
        char_chan.rx_char    = 8'd0;
        result_chan.ready    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        push_char(1'b0, 8'hFF);
        push_set("9", "9", "9", "9");
        push_set("1", "2", "x", "5");
        push_set("/", "5", "5", "5");
        push_char(1'b1, sctg_pkg::CHAR_ADC);
        push_char(1'b1, sctg_pkg::CHAR_STOP);
        push_char(1'b1, sctg_pkg::CHAR_START);
        push_char(1'b1, sctg_pkg::CHAR_START);
        push_char(1'b1, sctg_pkg::CHAR_STOP);
        push_char(1'b1, 8'h00);
        push_char(1'b1, 8'hFF);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            repeat (2) @(negedge clk);
            write_limit(sctg_pkg::LIMIT_W'(lim_set[p]));
            send_idle_pct  <= idle_set[p];
            recv_stall_pct <= stall_set[p];
            @(posedge clk);
            if (p == 0)
                hold_req = 1'b1;
            goal = queued_cnt + PHASE_ITEMS;
            while (queued_cnt < goal)
                push_random_command();
            wait_drained();
        end

        repeat (5) @(negedge clk);
        if (results_due.size() != 0 || taken_cnt != queued_cnt)
            note_error($sformatf("%0d results never arrived", results_due.size()));
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
rtl/sctg_pkg.sv
rtl/sctg_ifs.sv
rtl/serial_cmd_sine_table_generator.sv
rtl/sctg_checker.sv
test/tb.sv
